// ===== rtl/core/audio_sample_format_converter_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef AUDIO_SAMPLE_FORMAT_CONVERTER_MACROS_SVH
`define AUDIO_SAMPLE_FORMAT_CONVERTER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("converter check failed");

// Next-cycle implication, held off during reset.
`define ASFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("converter check failed");

`endif

// ===== rtl/core/asfc_pkg.sv =====
// Types, register map and G.711 helper functions for the format converter.
`default_nettype none

package asfc_pkg;

  // Sample encodings
  typedef enum logic [1:0] {
    ENC_S16  = 2'd0,
    ENC_S8   = 2'd1,
    ENC_ULAW = 2'd2
  } enc_t;

  // Register indexes
  localparam logic [1:0] REG_SRC_ENC = 2'd0;
  localparam logic [1:0] REG_DST_ENC = 2'd1;
  localparam logic [1:0] REG_SRC_CH  = 2'd2;
  localparam logic [1:0] REG_DST_CH  = 2'd3;

  localparam logic [1:0] CH_MONO   = 2'd1;
  localparam logic [1:0] CH_STEREO = 2'd2;

  localparam logic [16:0] ULAW_BIAS = 17'd132;

  // Decoded configuration handed to the datapath
  typedef struct packed {
    enc_t src_enc;
    enc_t dst_enc;
    logic src_stereo;
    logic dst_stereo;
  } cfg_t;

  // Unused code falls back to 16-bit linear
  function automatic enc_t norm_enc(input logic [1:0] code);
    enc_t e;
    priority if (code == ENC_S8) begin
      e = ENC_S8;
    end else if (code == ENC_ULAW) begin
      e = ENC_ULAW;
    end else begin
      e = ENC_S16;
    end
    return e;
  endfunction

  // G.711 mu-law expansion to 16-bit linear
  function automatic logic [15:0] ulaw_expand(input logic [7:0] code);
    logic [7:0]  u;
    logic [16:0] t;
    logic [16:0] r;
    u = ~code;
    t = (17'({u[3:0], 3'b000}) + ULAW_BIAS) << u[6:4];
    r = u[7] ? (ULAW_BIAS - t) : (t - ULAW_BIAS);
    return r[15:0];
  endfunction

  // G.711 mu-law compression of 16-bit linear, clipping at the top segment
  function automatic logic [7:0] ulaw_compress(input logic [15:0] lin);
    logic [16:0] l;
    logic [16:0] pv;
    logic [7:0]  mask;
    logic [2:0]  seg;
    logic [16:0] sh;
    logic [7:0]  code;
    l = {lin[15], lin};
    if (lin[15]) begin
      pv   = ULAW_BIAS - l;
      mask = 8'h7F;
    end else begin
      pv   = l + ULAW_BIAS;
      mask = 8'hFF;
    end
    seg = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (pv[i + 7]) seg = 3'(i);
    end
    sh = pv >> (4'({1'b0, seg}) + 4'd3);
    if (pv[16] || pv[15]) begin
      code = 8'h7F ^ mask;
    end else begin
      code = {1'b0, seg, sh[3:0]} ^ mask;
    end
    return code;
  endfunction

  // Signed halving, truncating toward zero
  function automatic logic [15:0] halve(input logic [16:0] s);
    logic [16:0] t;
    t = s + {16'b0, s[16]};
    return t[16:1];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/asfc_regs.sv =====
// APB configuration registers of the format converter.
`default_nettype none

module asfc_regs
  import asfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [1:0] src_enc;
  logic [1:0] dst_enc;
  logic [1:0] src_ch;
  logic [1:0] dst_ch;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_enc <= ENC_S16;
      dst_enc <= ENC_S16;
      src_ch  <= CH_MONO;
      dst_ch  <= CH_MONO;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SRC_ENC: src_enc <= pwdata[1:0];
        REG_DST_ENC: dst_enc <= pwdata[1:0];
        REG_SRC_CH:  src_ch  <= pwdata[1:0];
        REG_DST_CH:  dst_ch  <= pwdata[1:0];
        default:     src_enc <= src_enc;
      endcase
    end
  end

  // Read-back
  always_comb begin
    prdata = 32'b0;
    unique case (paddr[3:2])
      REG_SRC_ENC: prdata[1:0] = src_enc;
      REG_DST_ENC: prdata[1:0] = dst_enc;
      REG_SRC_CH:  prdata[1:0] = src_ch;
      REG_DST_CH:  prdata[1:0] = dst_ch;
      default:     prdata      = 32'b0;
    endcase
  end

  // Decoded view: unused codes fold to linear / mono
  assign cfg.src_enc    = norm_enc(src_enc);
  assign cfg.dst_enc    = norm_enc(dst_enc);
  assign cfg.src_stereo = (src_ch == CH_STEREO);
  assign cfg.dst_stereo = (dst_ch == CH_STEREO);

endmodule

`default_nettype wire

// ===== rtl/core/asfc_pair_avg.sv =====
// Stereo pair average in the source encoding.
`default_nettype none

module asfc_pair_avg
  import asfc_pkg::*;
(
  input  wire enc_t        enc,
  input  wire logic [15:0] left,
  input  wire logic [15:0] right,
  output logic      [15:0] avg
);

  logic [16:0] sum_s8;
  logic [16:0] sum_s16;
  logic [16:0] sum_ulaw;
  logic [15:0] exp_l;
  logic [15:0] exp_r;
  logic [15:0] half_s8;

  assign exp_l = ulaw_expand(left[7:0]);
  assign exp_r = ulaw_expand(right[7:0]);

  // Sums, sign extended to 17 bits
  assign sum_s8   = {{9{left[7]}}, left[7:0]} + {{9{right[7]}}, right[7:0]};
  assign sum_s16  = {left[15], left} + {right[15], right};
  assign sum_ulaw = {exp_l[15], exp_l} + {exp_r[15], exp_r};
  assign half_s8  = halve(sum_s8);

  always_comb begin
    unique case (enc)
      ENC_S8:   avg = {8'b0, half_s8[7:0]};
      ENC_ULAW: avg = {8'b0, ulaw_compress(halve(sum_ulaw))};
      default:  avg = halve(sum_s16);
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/asfc_encode.sv =====
// Encoding conversion of one sample via 16-bit linear.
`default_nettype none

module asfc_encode
  import asfc_pkg::*;
(
  input  wire cfg_t        cfg,
  input  wire logic [15:0] raw,
  output logic      [15:0] res
);

  logic [15:0] lin;

  // To linear
  always_comb begin
    unique case (cfg.src_enc)
      ENC_S8:   lin = {raw[7:0], 8'b0};
      ENC_ULAW: lin = ulaw_expand(raw[7:0]);
      default:  lin = raw;
    endcase
  end

  // From linear, or straight through when formats match
  always_comb begin
    if (cfg.src_enc == cfg.dst_enc) begin
      res = (cfg.src_enc == ENC_S16) ? raw : {8'b0, raw[7:0]};
    end else begin
      unique case (cfg.dst_enc)
        ENC_S8:   res = {8'b0, lin[15:8]};
        ENC_ULAW: res = {8'b0, ulaw_compress(lin)};
        default:  res = lin;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/audio_sample_format_converter.sv =====
// Top level: streaming PCM / mu-law sample and channel converter.
//
// Input beats (sample_in, block_end) arrive on in_valid/in_stall; results
// (sample_out, run_last, block_end_out) leave on out_valid/out_stall.
// Configuration is written through the APB port; the user must write it
// only while the stream is idle, which the block itself does not enforce.
// Pipeline: input register, pair average, encoding conversion into the
// output register. One beat is taken every cycle while in_stall is low;
// mono to stereo sends two results per beat, so the output register takes
// no new sample until both are sent. Stereo to mono takes two beats per
// result, the first being held in the pair register with no result.
// A stall on the output holds the output register; the stages behind it
// fill and then in_stall rises, so no beat is lost.
// Reset restores linear mono in and out and drops any pending pair half
// and all beats in flight.
`include "audio_sample_format_converter_macros.svh"
`default_nettype none

module audio_sample_format_converter
  import asfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] sample_in,
  input  wire logic        block_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] sample_out,
  output logic             run_last,
  output logic             block_end_out
);

  cfg_t        cfg;
  logic        in_take;
  logic [15:0] smp;
  logic        merge;
  logic        s1_load;

  // Pair state
  logic [15:0] held_left;
  logic        half_seen;

  // Stage 1: accepted beat
  logic        s1_valid;
  logic [15:0] s1_a;
  logic [15:0] s1_b;
  logic        s1_avg;
  logic        s1_dup;
  logic        s1_be;
  logic [15:0] s1_pair;
  logic        s1_free;

  // Stage 2: channel-converted sample
  logic        s2_valid;
  logic [15:0] s2_mid;
  logic        s2_dup;
  logic        s2_be;
  logic [15:0] s2_res;
  logic        s2_free;

  // Output register
  logic        out_more;
  logic        out_be;
  logic        out_take;
  logic        out_free;

  asfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Flow control, back to front
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || (out_take && !out_more);
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_stall = !s1_free;
  assign in_take  = in_valid && !in_stall;

  // Input decode
  assign smp     = (cfg.src_enc == ENC_S16) ? sample_in : {8'b0, sample_in[7:0]};
  assign merge   = cfg.src_stereo && !cfg.dst_stereo;
  assign s1_load = in_take && (!merge || half_seen);

  // Pair state: first half held, block end drops it
  always_ff @(posedge clk) begin
    if (rst) begin
      half_seen <= 1'b0;
      held_left <= 16'b0;
    end else if (in_take) begin
      if (merge && !half_seen && !block_end) begin
        half_seen <= 1'b1;
        held_left <= smp;
      end else if (merge || block_end) begin
        half_seen <= 1'b0;
      end
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && s1_load) begin
      s1_a   <= merge ? held_left : smp;
      s1_b   <= smp;
      s1_avg <= merge;
      s1_dup <= !cfg.src_stereo && cfg.dst_stereo;
      s1_be  <= block_end;
    end
  end

  asfc_pair_avg u_pair_avg (
    .enc   (cfg.src_enc),
    .left  (s1_a),
    .right (s1_b),
    .avg   (s1_pair)
  );

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_mid <= s1_avg ? s1_pair : s1_a;
      s2_dup <= s1_dup;
      s2_be  <= s1_be;
    end
  end

  asfc_encode u_encode (
    .cfg (cfg),
    .raw (s2_mid),
    .res (s2_res)
  );

  // Output register; a duplicated sample is sent a second time in place
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_more  <= 1'b0;
    end else if (out_take && out_more) begin
      out_more  <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
      out_more  <= s2_valid && s2_dup;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && out_more) begin
      run_last      <= 1'b1;
      block_end_out <= out_be;
    end else if (out_free && s2_valid) begin
      sample_out    <= s2_res;
      run_last      <= !s2_dup;
      block_end_out <= s2_be && !s2_dup;
      out_be        <= s2_be;
    end
  end

  // Checks
  `ASFC_ASSERT_NOW(a_first_copy_not_last, out_valid && out_more, !run_last && !block_end_out)
  `ASFC_ASSERT_NEXT(a_second_copy, out_take && out_more,
                    out_valid && run_last && $stable(sample_out))
  `ASFC_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid && s2_valid && out_valid)

endmodule

`default_nettype wire

// ===== test/asfc_checker.sv =====
// Scoreboard for the format converter: mirrors its state and checks every output beat.
`default_nettype none

module asfc_checker
  import asfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [15:0] sample_in,
  input  wire logic        block_end,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] sample_out,
  input  wire logic        run_last,
  input  wire logic        block_end_out,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MU_BIAS = 132;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        blk;
  } out_beat_t;

  out_beat_t   beats_due[$];

  // Shadow copy of the register file and the pair state
  logic [1:0]  src_enc_q;
  logic [1:0]  dst_enc_q;
  logic [1:0]  src_ch_q;
  logic [1:0]  dst_ch_q;
  logic [15:0] left_half;
  logic        half_waiting;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Unused code 3 behaves as 16-bit linear
  function automatic enc_t coding_of(input logic [1:0] code);
    if (code == ENC_S8) return ENC_S8;
    if (code == ENC_ULAW) return ENC_ULAW;
    return ENC_S16;
  endfunction

  function automatic logic [15:0] trim_raw(input logic [15:0] v, input enc_t enc);
    return (enc == ENC_S16) ? v : {8'h00, v[7:0]};
  endfunction

  // G.711 mu-law code to linear
  function automatic int mu_to_linear(input logic [7:0] code);
    logic [7:0] u;
    int         t;
    u = ~code;
    t = (int'(u[3:0]) * 8 + MU_BIAS) << u[6:4];
    return u[7] ? MU_BIAS - t : t - MU_BIAS;
  endfunction

  // Linear to G.711 mu-law, clipping beyond the top segment
  function automatic logic [7:0] linear_to_mu(input int lin);
    int         v;
    int         seg;
    logic [7:0] mask;
    if (lin < 0) begin
      v    = MU_BIAS - lin;
      mask = 8'h7F;
    end else begin
      v    = lin + MU_BIAS;
      mask = 8'hFF;
    end
    seg = 0;
    while (seg < 8 && v > (256 << seg) - 1) seg++;
    if (seg >= 8) return 8'h7F ^ mask;
    return 8'((seg << 4) | ((v >> (seg + 3)) & 15)) ^ mask;
  endfunction

  // Mean of a left/right pair in the source coding, truncated toward zero
  function automatic logic [15:0] pair_mean(input logic [15:0] a, input logic [15:0] b,
                                             input enc_t enc);
    int s;
    case (enc)
      ENC_S8: begin
        s = int'($signed(a[7:0])) + int'($signed(b[7:0]));
        return {8'h00, 8'(s / 2)};
      end
      ENC_ULAW: begin
        s = mu_to_linear(a[7:0]) + mu_to_linear(b[7:0]);
        return {8'h00, linear_to_mu(s / 2)};
      end
      default: begin
        s = int'($signed(a)) + int'($signed(b));
        return 16'(s / 2);
      end
    endcase
  endfunction

  function automatic logic [15:0] recode(input logic [15:0] raw, input enc_t se,
                                         input enc_t de);
    int          lin;
    logic [31:0] lin_bits;
    if (se == de) return trim_raw(raw, se);
    case (se)
      ENC_S8:   lin = int'($signed(raw[7:0])) * 256;
      ENC_ULAW: lin = mu_to_linear(raw[7:0]);
      default:  lin = int'($signed(raw));
    endcase
    lin_bits = lin;
    case (de)
      ENC_S8:   return {8'h00, lin_bits[15:8]};
      ENC_ULAW: return {8'h00, linear_to_mu(lin)};
      default:  return lin_bits[15:0];
    endcase
  endfunction

  // Work out the output beats caused by one input beat
  task automatic convert_beat(input logic [15:0] smp_raw, input logic be);
    enc_t        se;
    enc_t        de;
    logic        s_st;
    logic        d_st;
    logic [15:0] smp;
    logic [15:0] mid;
    logic [15:0] res;
    int          n;
    out_beat_t   b;
    se   = coding_of(src_enc_q);
    de   = coding_of(dst_enc_q);
    s_st = (src_ch_q == CH_STEREO);
    d_st = (dst_ch_q == CH_STEREO);
    smp  = trim_raw(smp_raw, se);
    if (s_st && !d_st) begin
      if (!half_waiting) begin
        // first half is held; a block end here drops it
        if (!be) begin
          left_half    = smp;
          half_waiting = 1'b1;
        end
        return;
      end
      mid          = pair_mean(left_half, smp, se);
      half_waiting = 1'b0;
      n            = 1;
    end else begin
      mid = smp;
      n   = (!s_st && d_st) ? 2 : 1;
      if (be) half_waiting = 1'b0;
    end
    res = recode(mid, se, de);
    for (int k = 0; k < n; k++) begin
      b.sample = res;
      b.last   = (k == n - 1);
      b.blk    = (k == n - 1) ? be : 1'b0;
      beats_due.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      src_enc_q    = ENC_S16;
      dst_enc_q    = ENC_S16;
      src_ch_q     = CH_MONO;
      dst_ch_q     = CH_MONO;
      left_half    = '0;
      half_waiting = 1'b0;
      beats_due.delete();
    end else begin
      // output beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got sample_out %h run_last %b blk %b",
                   $time, sample_out, run_last, block_end_out);
          errors++;
        end else begin
          want = beats_due.pop_front();
          if (sample_out !== want.sample) begin
            $display("%0t: sample_out expected %h got %h", $time, want.sample, sample_out);
            errors++;
          end
          if (run_last !== want.last) begin
            $display("%0t: run_last expected %b got %b", $time, want.last, run_last);
            errors++;
          end
          if (block_end_out !== want.blk) begin
            $display("%0t: block_end_out expected %b got %b", $time, want.blk,
                     block_end_out);
            errors++;
          end
        end
      end
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SRC_ENC: src_enc_q = pwdata[1:0];
          REG_DST_ENC: dst_enc_q = pwdata[1:0];
          REG_SRC_CH:  src_ch_q  = pwdata[1:0];
          REG_DST_CH:  dst_ch_q  = pwdata[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) convert_beat(sample_in, block_end);
    end
    pending = beats_due.size();
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench top: drives stimulus and register writes into the converter and gives the verdict.
`default_nettype none

module tb
  import asfc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES      = 40;
  localparam int PHASE_BEATS = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] sample_in = '0;
  logic        block_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] sample_out;
  logic        run_last;
  logic        block_end_out;
  int          errors;
  int          pending;

  // Pacing knobs for the sender and the receiver
  bit          tx_no_gaps = 1'b0;
  bit          rx_no_stall = 1'b0;
  bit          rx_hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  audio_sample_format_converter u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .sample_in, .block_end,
    .out_valid, .out_stall, .sample_out, .run_last, .block_end_out
  );

  asfc_checker u_chk (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .sample_in, .block_end,
    .out_valid, .out_stall, .sample_out, .run_last, .block_end_out,
    .errors, .pending
  );

  // Watchdog
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stall before each beat, plus long hold-offs on request
  initial begin
    int n;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (rx_hold_off) begin
        rx_hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      n = rx_no_stall ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid && !out_stall) break;
      end
    end
  end

  // One APB write, ending with psel low so writes never overlap
  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {30'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_format(input logic [1:0] se, input logic [1:0] de,
                            input logic [1:0] sc, input logic [1:0] dc);
    write_reg(REG_SRC_ENC, se);
    write_reg(REG_DST_ENC, de);
    write_reg(REG_SRC_CH, sc);
    write_reg(REG_DST_CH, dc);
  endtask

  // Offer one beat after a random gap unless tx_no_gaps is set; returns on the accepting edge
  task automatic send_beat(input logic [15:0] smp, input logic be);
    int n;
    n = tx_no_gaps ? 0 : $urandom_range(0, 12);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= smp;
    block_end <= be;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Let the pipe empty, then give it time to finish any beat with no output
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return {8'($urandom()), 8'h80};
      5: return {8'($urandom()), 8'h7F};
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic [1:0] se;
    logic [1:0] de;
    logic [1:0] sc;
    logic [1:0] dc;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes in the reset format
    send_beat(16'h0000, 1'b0);
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'hFFFF, 1'b1);
    drain_pipe();

    // 8-bit to mu-law, mono to stereo; high byte must be ignored
    set_format(ENC_S8, ENC_ULAW, CH_MONO, CH_STEREO);
    send_beat(16'hFF80, 1'b0);
    send_beat(16'h007F, 1'b1);
    drain_pipe();

    // mu-law pairs averaged; block end on a first half drops it
    set_format(ENC_ULAW, ENC_S16, CH_STEREO, CH_MONO);
    send_beat(16'h0000, 1'b0);
    send_beat(16'h00FF, 1'b0);
    send_beat(16'h0080, 1'b1);
    send_beat(16'hAB7F, 1'b0);
    drain_pipe();
    // pending half survives a register write (and unused dest code)
    write_reg(REG_DST_ENC, 2'd3);
    send_beat(16'h0000, 1'b0);
    drain_pipe();

    // unused source code and unused channel counts
    set_format(2'd3, ENC_S8, 2'd0, 2'd3);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h7FFF, 1'b1);
    drain_pipe();

    // linear pairs into mu-law at both clipping ends
    set_format(ENC_S16, ENC_ULAW, CH_STEREO, CH_MONO);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h7FFF, 1'b0);
    send_beat(16'h7FFF, 1'b1);
    drain_pipe();

    // Random phases: every legal format first, then arbitrary register codes
    for (int p = 0; p < PHASES; p++) begin
      if (p < 36) begin
        se = 2'(p % 3);
        de = 2'((p / 3) % 3);
        sc = (((p / 9) % 2) == 0) ? CH_MONO : CH_STEREO;
        dc = (((p / 18) % 2) == 0) ? CH_MONO : CH_STEREO;
      end else begin
        se = 2'($urandom_range(0, 3));
        de = 2'($urandom_range(0, 3));
        sc = 2'($urandom_range(0, 3));
        dc = 2'($urandom_range(0, 3));
      end
      set_format(se, de, sc, dc);
      tx_no_gaps  = (p % 5 == 0) || (p == 11) || (p == 28);
      rx_no_stall = (p % 7 == 3);
      if (p == 11 || p == 28) rx_hold_off = 1'b1;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        send_beat(pick_sample(), $urandom_range(0, 15) == 0);
      end
      drain_pipe();
    end

    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== audio_sample_format_converter.f =====
+incdir+rtl/core
rtl/core/asfc_pkg.sv
rtl/core/asfc_regs.sv
rtl/core/asfc_pair_avg.sv
rtl/core/asfc_encode.sv
rtl/core/audio_sample_format_converter.sv
test/asfc_checker.sv
test/tb.sv
